FILE: design/plti_pkg.sv
// Shared types, widths and codes for the piecewise-linear table interpolator.
package plti_pkg;

   // Field widths
   localparam int RAD_W      = 32;               // radius, unsigned Q12.20
   localparam int VAL_W      = 40;               // property value, signed Q24.16
   localparam int MAG_W      = VAL_W + 1;        // magnitude of a value difference
   localparam int PROD_W     = MAG_W + RAD_W;    // magnitude times radius fraction
   localparam int KNOT_W     = RAD_W + 3 * VAL_W;
   localparam int REQ_DATA_W = KNOT_W;           // 152 bits, whole bytes
   localparam int REQ_USER_W = 2;
   localparam int RSP_DATA_W = 3 * VAL_W;        // 120 bits, whole bytes
   localparam int RSP_USER_W = 3;

   // Step counts of the shared multiply/divide unit
   localparam int          STEP_W   = 6;
   localparam logic [5:0]  MUL_LAST = STEP_W'(RAD_W - 1);
   localparam logic [5:0]  DIV_LAST = STEP_W'(MAG_W - 1);

   // Request codes carried on req_tuser
   localparam logic [1:0] REQ_CLEAR  = 2'd0;
   localparam logic [1:0] REQ_APPEND = 2'd1;
   localparam logic [1:0] REQ_QUERY  = 2'd2;

   // Range flag codes
   localparam logic [1:0] RANGE_INSIDE = 2'd0;
   localparam logic [1:0] RANGE_BELOW  = 2'd1;
   localparam logic [1:0] RANGE_ABOVE  = 2'd2;

   // Property selectors
   localparam logic [1:0] PROP_DENSITY = 2'd0;
   localparam logic [1:0] PROP_BULK    = 2'd1;
   localparam logic [1:0] PROP_SHEAR   = 2'd2;

   // One stored knot
   typedef struct packed {
      logic [VAL_W-1:0] shear;
      logic [VAL_W-1:0] bulk;
      logic [VAL_W-1:0] density;
      logic [RAD_W-1:0] radius;
   } knot_type;

   // Command and status between sequencer and multiply/divide unit
   typedef struct packed {
      logic             start;
      logic [MAG_W-1:0] mag;
      logic [RAD_W-1:0] num;
      logic [RAD_W-1:0] den;
   } md_cmd_type;

   typedef struct packed {
      logic             done;
      logic [MAG_W-1:0] quot;
   } md_rsp_type;

   // Sequencer states
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN,
      ST_LAUNCH,
      ST_WAIT,
      ST_DONE
   } seq_state_type;

   // Multiply/divide unit states
   typedef enum logic [1:0] {
      MD_IDLE,
      MD_MUL,
      MD_DIV,
      MD_DONE
   } md_state_type;

   // Pick one property out of a knot
   function automatic logic [VAL_W-1:0] knot_prop(knot_type k, logic [1:0] sel);
      logic [VAL_W-1:0] v;
      case (sel)
         PROP_DENSITY: v = k.density;
         PROP_BULK:    v = k.bulk;
         default:      v = k.shear;
      endcase
      return v;
   endfunction

endpackage

FILE: design/piecewise_linear_table_interp.sv
// Top level: knot table, segment scan sequencer and interpolation control.
//
// Usage
//   Requests arrive as beats on the req_ stream: req_tuser carries the request
//   code (clear, append, query) and req_tdata the radius and three property
//   values. Only a query gives a beat on the rsp_ stream, carrying the three
//   interpolated properties in rsp_tdata and result_valid / range_flag in
//   rsp_tuser. Code 3 is dropped without effect.
// Request handling
//   Clear and append do not hold the stream; the next beat is taken at once.
//   A query walks the stored knots one per cycle through the table RAM's
//   single registered read port until a bracketing segment or the last knot
//   is found. An interior hit then runs the shared multiply/divide unit once
//   per property (32 multiply steps, 41 divide steps); clamped, zero-width
//   and empty-table queries skip the unit. req_tready is low from acceptance
//   of a query until its result is handed to the output register.
// Reset and stalls
//   Reset empties the table and drops any pending result. A held result
//   sits in the output register while rsp_tready is low; clears and appends
//   are still taken, and a following query stalls only at its end.
module piecewise_linear_table_interp #(
   parameter int TABLE_DEPTH = 256
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   // radius_in [31:0], density_in [71:32], bulk_in [111:72], shear_in [151:112]
   input  logic [plti_pkg::REQ_DATA_W-1:0] req_tdata,
   // req_type [1:0]
   input  logic [plti_pkg::REQ_USER_W-1:0] req_tuser,
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   // density_out [39:0], bulk_out [79:40], shear_out [119:80]
   output logic [plti_pkg::RSP_DATA_W-1:0] rsp_tdata,
   // result_valid [0], range_flag [2:1]
   output logic [plti_pkg::RSP_USER_W-1:0] rsp_tuser
);
   import plti_pkg::*;

   localparam int ADDR_W = $clog2(TABLE_DEPTH);
   localparam int CNT_W  = $clog2(TABLE_DEPTH + 1);

   seq_state_type      state_ff, state_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic [ADDR_W-1:0]  idx_ff, idx_in;
   logic [ADDR_W-1:0]  didx_ff, didx_in;
   logic               dvalid_ff, dvalid_in;
   logic [RAD_W-1:0]   radius_ff, radius_in;
   knot_type           lo_ff, lo_in;
   knot_type           hi_ff, hi_in;
   knot_type           first_ff, first_in;
   logic [1:0]         prop_ff, prop_in;
   logic [VAL_W-1:0]   res_den_ff, res_den_in;
   logic [VAL_W-1:0]   res_bulk_ff, res_bulk_in;
   logic [VAL_W-1:0]   res_shear_ff, res_shear_in;
   logic               res_ok_ff, res_ok_in;
   logic [1:0]         res_flag_ff, res_flag_in;
   logic               rsp_tvalid_ff, rsp_tvalid_in;
   logic [RSP_DATA_W-1:0] rsp_tdata_ff, rsp_tdata_in;
   logic [RSP_USER_W-1:0] rsp_tuser_ff, rsp_tuser_in;

   logic               accept;
   logic               out_free;
   logic               wr_en;
   knot_type           wr_knot;
   logic [KNOT_W-1:0]  rd_data;
   knot_type           entry;
   logic               seg_hit;
   logic               seg_flat;
   logic               is_first;
   logic               is_last;
   logic [VAL_W-1:0]   p1;
   logic [VAL_W-1:0]   p2;
   logic [MAG_W-1:0]   diff;
   logic               neg;
   logic [VAL_W-1:0]   quot;
   logic [VAL_W-1:0]   lerp_val;
   md_cmd_type         md_cmd;
   md_rsp_type         md_rsp;

   // Knot table
   plti_ram #(
      .WIDTH (KNOT_W),
      .DEPTH (TABLE_DEPTH)
   ) u_table (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (count_ff[ADDR_W-1:0]),
      .wr_data (wr_knot),
      .rd_addr (idx_ff),
      .rd_data (rd_data)
   );

   // Shared multiply/divide unit
   plti_muldiv u_muldiv (
      .clock (clock),
      .reset (reset),
      .cmd   (md_cmd),
      .rsp   (md_rsp)
   );

   assign accept   = req_tvalid && req_tready;
   assign out_free = !rsp_tvalid_ff || rsp_tready;

   // Append writes the next free slot unless the table is full
   assign wr_en = accept && (req_tuser == REQ_APPEND) && (count_ff != CNT_W'(TABLE_DEPTH));

   assign wr_knot.radius  = req_tdata[RAD_W-1:0];
   assign wr_knot.density = req_tdata[RAD_W+VAL_W-1:RAD_W];
   assign wr_knot.bulk    = req_tdata[RAD_W+2*VAL_W-1:RAD_W+VAL_W];
   assign wr_knot.shear   = req_tdata[RAD_W+3*VAL_W-1:RAD_W+2*VAL_W];

   // Segment test on the knot just read against the one before it
   assign entry    = knot_type'(rd_data);
   assign is_first = (didx_ff == '0);
   assign is_last  = (CNT_W'(didx_ff) == count_ff - CNT_W'(1));
   assign seg_hit  = !is_first && (radius_ff >= lo_ff.radius) && (radius_ff <= entry.radius);
   assign seg_flat = (lo_ff.radius == entry.radius);

   // Interpolation operands for the current property
   assign p1   = knot_prop(lo_ff, prop_ff);
   assign p2   = knot_prop(hi_ff, prop_ff);
   assign diff = {p2[VAL_W-1], p2} - {p1[VAL_W-1], p1};
   assign neg  = diff[MAG_W-1];
   assign quot = md_rsp.quot[VAL_W-1:0];
   assign lerp_val = p1 + (neg ? (VAL_W'(0) - quot) : quot);

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept && req_tuser == REQ_QUERY) begin
               state_in = (count_ff == '0) ? ST_DONE : ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (dvalid_ff) begin
               if (seg_hit) begin
                  state_in = seg_flat ? ST_DONE : ST_LAUNCH;
               end else if (is_last) begin
                  state_in = ST_DONE;
               end
            end
         end
         ST_LAUNCH: state_in = ST_WAIT;
         ST_WAIT: begin
            if (md_rsp.done) begin
               state_in = (prop_ff == PROP_SHEAR) ? ST_DONE : ST_LAUNCH;
            end
         end
         ST_DONE: if (out_free) state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   // Outputs of the sequencer
   always_comb begin
      req_tready   = (state_ff == ST_IDLE);
      md_cmd.start = (state_ff == ST_LAUNCH);
      md_cmd.mag   = neg ? (MAG_W'(0) - diff) : diff;
      md_cmd.num   = radius_ff - lo_ff.radius;
      md_cmd.den   = hi_ff.radius - lo_ff.radius;
   end

   // Datapath
   always_comb begin
      count_in     = count_ff;
      idx_in       = idx_ff;
      didx_in      = didx_ff;
      dvalid_in    = dvalid_ff;
      radius_in    = radius_ff;
      lo_in        = lo_ff;
      hi_in        = hi_ff;
      first_in     = first_ff;
      prop_in      = prop_ff;
      res_den_in   = res_den_ff;
      res_bulk_in  = res_bulk_ff;
      res_shear_in = res_shear_ff;
      res_ok_in    = res_ok_ff;
      res_flag_in  = res_flag_ff;

      // table updates and query start
      if (accept) begin
         case (req_tuser)
            REQ_CLEAR:  count_in = '0;
            REQ_APPEND: if (wr_en) count_in = count_ff + CNT_W'(1);
            REQ_QUERY: begin
               radius_in    = req_tdata[RAD_W-1:0];
               idx_in       = '0;
               dvalid_in    = 1'b0;
               res_ok_in    = (count_ff != '0);
               res_flag_in  = RANGE_INSIDE;
               res_den_in   = '0;
               res_bulk_in  = '0;
               res_shear_in = '0;
            end
            default: ;
         endcase
      end

      // one knot per cycle through the read port
      if (state_ff == ST_SCAN) begin
         idx_in    = idx_ff + ADDR_W'(1);
         didx_in   = idx_ff;
         dvalid_in = 1'b1;
         if (dvalid_ff) begin
            lo_in = entry;
            if (is_first) begin
               first_in = entry;
            end
            if (seg_hit) begin
               lo_in   = lo_ff;
               hi_in   = entry;
               prop_in = PROP_DENSITY;
               // zero-width segment answers p1 directly
               res_den_in   = lo_ff.density;
               res_bulk_in  = lo_ff.bulk;
               res_shear_in = lo_ff.shear;
               res_flag_in  = RANGE_INSIDE;
            end else if (is_last) begin
               if (radius_ff < (is_first ? entry.radius : first_ff.radius)) begin
                  res_den_in   = is_first ? entry.density : first_ff.density;
                  res_bulk_in  = is_first ? entry.bulk    : first_ff.bulk;
                  res_shear_in = is_first ? entry.shear   : first_ff.shear;
                  res_flag_in  = RANGE_BELOW;
               end else begin
                  res_den_in   = entry.density;
                  res_bulk_in  = entry.bulk;
                  res_shear_in = entry.shear;
                  res_flag_in  = RANGE_ABOVE;
               end
            end
         end
      end

      // collect each property from the shared unit
      if (state_ff == ST_WAIT && md_rsp.done) begin
         case (prop_ff)
            PROP_DENSITY: res_den_in  = lerp_val;
            PROP_BULK:    res_bulk_in = lerp_val;
            default:      res_shear_in = lerp_val;
         endcase
         prop_in = prop_ff + 2'd1;
      end
   end

   // Output register
   always_comb begin
      rsp_tvalid_in = rsp_tvalid_ff;
      rsp_tdata_in  = rsp_tdata_ff;
      rsp_tuser_in  = rsp_tuser_ff;
      if (rsp_tready) begin
         rsp_tvalid_in = 1'b0;
      end
      if (state_ff == ST_DONE && out_free) begin
         rsp_tvalid_in = 1'b1;
         rsp_tdata_in  = {res_shear_ff, res_bulk_ff, res_den_ff};
         rsp_tuser_in  = {res_flag_ff, res_ok_ff};
      end
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_tdata_ff;
   assign rsp_tuser  = rsp_tuser_ff;

   // Registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         count_ff      <= '0;
         dvalid_ff     <= 1'b0;
         rsp_tvalid_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         count_ff      <= count_in;
         dvalid_ff     <= dvalid_in;
         rsp_tvalid_ff <= rsp_tvalid_in;
      end
      idx_ff       <= idx_in;
      didx_ff      <= didx_in;
      radius_ff    <= radius_in;
      lo_ff        <= lo_in;
      hi_ff        <= hi_in;
      first_ff     <= first_in;
      prop_ff      <= prop_in;
      res_den_ff   <= res_den_in;
      res_bulk_ff  <= res_bulk_in;
      res_shear_ff <= res_shear_in;
      res_ok_ff    <= res_ok_in;
      res_flag_ff  <= res_flag_in;
      rsp_tdata_ff <= rsp_tdata_in;
      rsp_tuser_ff <= rsp_tuser_in;
   end

endmodule

FILE: design/plti_ram.sv
// Generic simple dual-port RAM with registered read.
module plti_ram #(
   parameter int  WIDTH  = 8,
   parameter int  DEPTH  = 16,
   localparam int ADDR_W = $clog2(DEPTH)
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // Registered read port
   always_ff @(posedge clock) begin
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: design/plti_muldiv.sv
// Serial unit: floor(mag * num / den) by shift-add multiply then restoring divide.
module plti_muldiv (
   input  logic                 clock,
   input  logic                 reset,
   input  plti_pkg::md_cmd_type cmd,
   output plti_pkg::md_rsp_type rsp
);
   import plti_pkg::*;

   md_state_type       state_ff, state_in;
   logic [STEP_W-1:0]  cnt_ff, cnt_in;
   logic [PROD_W-1:0]  acc_ff, acc_in;
   logic [MAG_W-1:0]   mag_ff, mag_in;
   logic [RAD_W-1:0]   den_ff, den_in;
   logic [RAD_W-1:0]   rem_ff, rem_in;

   logic [MAG_W:0]     mul_sum;
   logic [PROD_W-1:0]  mul_next;
   logic [RAD_W:0]     div_trial;
   logic [RAD_W:0]     div_diff;
   logic               div_ge;

   // Shared adder for the multiply step: add mag into the upper half, shift right
   assign mul_sum  = {1'b0, acc_ff[PROD_W-1:RAD_W]} + (acc_ff[0] ? {1'b0, mag_ff} : '0);
   assign mul_next = {mul_sum, acc_ff[RAD_W-1:1]};

   // Divide step: bring down the next dividend bit and trial-subtract
   assign div_trial = {rem_ff, acc_ff[MAG_W-1]};
   assign div_diff  = div_trial - {1'b0, den_ff};
   assign div_ge    = (div_trial >= {1'b0, den_ff});

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         MD_IDLE: if (cmd.start) state_in = MD_MUL;
         MD_MUL:  if (cnt_ff == MUL_LAST) state_in = MD_DIV;
         MD_DIV:  if (cnt_ff == DIV_LAST) state_in = MD_DONE;
         MD_DONE: state_in = MD_IDLE;
         default: state_in = MD_IDLE;
      endcase
   end

   // Outputs
   always_comb begin
      rsp.done = (state_ff == MD_DONE);
      rsp.quot = acc_ff[MAG_W-1:0];
   end

   // Datapath
   always_comb begin
      cnt_in = cnt_ff;
      acc_in = acc_ff;
      mag_in = mag_ff;
      den_in = den_ff;
      rem_in = rem_ff;
      case (state_ff)
         MD_IDLE: begin
            if (cmd.start) begin
               mag_in = cmd.mag;
               den_in = cmd.den;
               acc_in = {{MAG_W{1'b0}}, cmd.num};
               cnt_in = '0;
            end
         end
         MD_MUL: begin
            acc_in = mul_next;
            cnt_in = cnt_ff + STEP_W'(1);
            if (cnt_ff == MUL_LAST) begin
               // high product bits are below den, so they seed the remainder
               rem_in = mul_next[PROD_W-1:MAG_W];
               cnt_in = '0;
            end
         end
         MD_DIV: begin
            rem_in              = div_ge ? div_diff[RAD_W-1:0] : div_trial[RAD_W-1:0];
            acc_in[MAG_W-1:0]   = {acc_ff[MAG_W-2:0], div_ge};
            cnt_in              = cnt_ff + STEP_W'(1);
         end
         default: ;
      endcase
   end

   // Registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= MD_IDLE;
      end else begin
         state_ff <= state_in;
      end
      cnt_ff <= cnt_in;
      acc_ff <= acc_in;
      mag_ff <= mag_in;
      den_ff <= den_in;
      rem_ff <= rem_in;
   end

endmodule

FILE: design/plti_checker.sv
// Port-level checks for the interpolator, bound to the top level.
module plti_checker (
   input logic                            clock,
   input logic                            reset,
   input logic                            req_tvalid,
   input logic                            req_tready,
   input logic [plti_pkg::REQ_USER_W-1:0] req_tuser,
   input logic                            rsp_tvalid,
   input logic                            rsp_tready,
   input logic [plti_pkg::RSP_DATA_W-1:0] rsp_tdata,
   input logic [plti_pkg::RSP_USER_W-1:0] rsp_tuser
);
   import plti_pkg::*;

   // A stalled result beat holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("result beat changed while stalled");

   // An empty-table answer carries zero values and the inside flag
   a_empty_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser[0] |-> rsp_tdata == '0 && rsp_tuser[2:1] == RANGE_INSIDE)
      else $error("invalid result with non-zero payload");

   // Range flag only takes its three codes
   a_flag_code: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tuser[2:1] == RANGE_INSIDE || rsp_tuser[2:1] == RANGE_BELOW
                  || rsp_tuser[2:1] == RANGE_ABOVE)
      else $error("range flag out of range");

   // A query occupies the block, so ready drops right after it is taken
   a_query_busy: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && req_tuser == REQ_QUERY |=> !req_tready)
      else $error("ready stayed high after a query");

endmodule

bind piecewise_linear_table_interp plti_checker u_plti_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .req_tuser  (req_tuser),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);

FILE: verif/tb.sv
// Self-checking testbench for the piecewise-linear knot table interpolator.
`timescale 1ns / 1ps

module tb;
   import plti_pkg::*;

   localparam int         TABLE_DEPTH = 256;
   localparam int         ITEM_GOAL   = 1850;
   localparam logic [1:0] REQ_UNUSED  = 2'd3;
   localparam logic [39:0] VAL_MAX    = 40'h7F_FFFF_FFFF;
   localparam logic [39:0] VAL_MIN    = 40'h80_0000_0000;

   // One request beat as queued for the driver
   typedef struct packed {
      logic [39:0] shear;
      logic [39:0] bulk;
      logic [39:0] density;
      logic [31:0] radius;
      logic [1:0]  kind;
      logic        drain;   // hold off until every pending result has come
   } req_beat_type;

   // One lookup answer
   typedef struct packed {
      logic [39:0] density;
      logic [39:0] bulk;
      logic [39:0] shear;
      logic        hit_valid;
      logic [1:0]  range_code;
   } lookup_result_type;

   logic                  clock;
   logic                  reset      = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata  = '0;
   logic [REQ_USER_W-1:0] req_tuser  = '0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic [RSP_USER_W-1:0] rsp_tuser;

   // Stimulus and scoreboard
   req_beat_type      pending_beats[$];
   lookup_result_type expected_results[$];
   req_beat_type      cur_beat;
   logic           req_beat_taken = 1'b0;
   int             beats_accepted = 0;
   int             total_beats    = 1;
   int             results_seen   = 0;
   int             error_count    = 0;

   // Generator's view of the table, used to aim query radii
   logic [31:0]    table_plan[$];
   int             item_total = 0;
   logic           hold_next  = 1'b0;

   // Predictor's copy of the table
   logic [31:0]    knot_radius  [TABLE_DEPTH];
   logic [39:0]    knot_density [TABLE_DEPTH];
   logic [39:0]    knot_bulk    [TABLE_DEPTH];
   logic [39:0]    knot_shear   [TABLE_DEPTH];
   int             knot_count = 0;

   piecewise_linear_table_interp #(
      .TABLE_DEPTH (TABLE_DEPTH)
   ) u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // ------------------------------------------------------------------
   // Prediction
   // ------------------------------------------------------------------

   // p1 + (p2-p1)*num/den, quotient truncated toward zero, 40-bit wrap
   function automatic logic [39:0] lerp_prop(logic [39:0] p1, logic [39:0] p2,
                                             logic [31:0] num, logic [31:0] den);
      logic [40:0] diff;
      logic [40:0] mag;
      logic [72:0] prod;
      logic [72:0] quot;
      diff = {p2[39], p2} - {p1[39], p1};
      mag  = diff[40] ? (~diff + 41'd1) : diff;
      prod = mag * num;
      quot = prod / den;
      return diff[40] ? (p1 - quot[39:0]) : (p1 + quot[39:0]);
   endfunction

   // Update the table copy; a query queues its answer
   task automatic apply_request(req_beat_type b);
      lookup_result_type res;
      logic           found;
      logic [31:0]    r1;
      logic [31:0]    r2;
      int             i;
      case (b.kind)
         REQ_CLEAR: knot_count = 0;
         REQ_APPEND: begin
            if (knot_count < TABLE_DEPTH) begin
               knot_radius[knot_count]  = b.radius;
               knot_density[knot_count] = b.density;
               knot_bulk[knot_count]    = b.bulk;
               knot_shear[knot_count]   = b.shear;
               knot_count++;
            end
         end
         REQ_QUERY: begin
            res   = '0;
            found = 1'b0;
            if (knot_count != 0) begin
               res.hit_valid = 1'b1;
               // first segment that brackets the radius wins
               for (i = 0; i + 1 < knot_count; i++) begin
                  r1 = knot_radius[i];
                  r2 = knot_radius[i + 1];
                  if (!found && b.radius >= r1 && b.radius <= r2) begin
                     found          = 1'b1;
                     res.range_code = RANGE_INSIDE;
                     if (r1 == r2) begin
                        res.density = knot_density[i];
                        res.bulk    = knot_bulk[i];
                        res.shear   = knot_shear[i];
                     end else begin
                        res.density = lerp_prop(knot_density[i], knot_density[i + 1],
                                                b.radius - r1, r2 - r1);
                        res.bulk    = lerp_prop(knot_bulk[i], knot_bulk[i + 1],
                                                b.radius - r1, r2 - r1);
                        res.shear   = lerp_prop(knot_shear[i], knot_shear[i + 1],
                                                b.radius - r1, r2 - r1);
                     end
                  end
               end
               // clamp to an end knot
               if (!found) begin
                  if (b.radius < knot_radius[0]) begin
                     res.density    = knot_density[0];
                     res.bulk       = knot_bulk[0];
                     res.shear      = knot_shear[0];
                     res.range_code = RANGE_BELOW;
                  end else begin
                     res.density    = knot_density[knot_count - 1];
                     res.bulk       = knot_bulk[knot_count - 1];
                     res.shear      = knot_shear[knot_count - 1];
                     res.range_code = RANGE_ABOVE;
                  end
               end
            end
            expected_results.insert(expected_results.size(), res);
         end
         default: ;
      endcase
   endtask

   // ------------------------------------------------------------------
   // Checking
   // ------------------------------------------------------------------

   task automatic report_fault(string msg);
      $display("[%0t] mismatch: %s", $realtime, msg);
      error_count++;
   endtask

   task automatic check_field(string name, logic [39:0] got, logic [39:0] want);
      if (got !== want)
         report_fault($sformatf("result %0d %s got %h want %h", results_seen, name, got, want));
   endtask

   // Monitor: result beats first, then request beats into the predictor
   always @(posedge clock) begin
      lookup_result_type want;
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) begin
            if (expected_results.size() == 0) begin
               report_fault($sformatf("result beat with none expected: data %h user %h",
                                      rsp_tdata, rsp_tuser));
            end else begin
               want = expected_results.pop_front();
               check_field("density", rsp_tdata[39:0], want.density);
               check_field("bulk", rsp_tdata[79:40], want.bulk);
               check_field("shear", rsp_tdata[119:80], want.shear);
               check_field("result_valid", 40'(rsp_tuser[0]), 40'(want.hit_valid));
               check_field("range_flag", 40'(rsp_tuser[2:1]), 40'(want.range_code));
            end
            results_seen++;
         end
         if (req_tvalid && req_tready) begin
            apply_request(cur_beat);
            req_beat_taken = 1'b1;
            beats_accepted++;
         end
      end
   end

   // ------------------------------------------------------------------
   // Driver: changes inputs on the falling edge
   // ------------------------------------------------------------------

   always @(negedge clock) begin
      int load_phase;
      int send_idle_pct;
      int recv_idle_pct;
      load_phase = beats_accepted * 3 / total_beats;
      case (load_phase)
         0:       begin send_idle_pct = 24; recv_idle_pct = 83; end
         1:       begin send_idle_pct = 83; recv_idle_pct = 24; end
         default: begin send_idle_pct = 0;  recv_idle_pct = 0;  end
      endcase

      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (!req_tvalid || req_beat_taken) begin
         req_beat_taken = 1'b0;
         if (pending_beats.size() == 0) begin
            req_tvalid <= 1'b0;
         end else if (pending_beats[0].drain && expected_results.size() != 0) begin
            req_tvalid <= 1'b0;
         end else if ($urandom_range(99) < send_idle_pct) begin
            req_tvalid <= 1'b0;
         end else begin
            cur_beat = pending_beats.pop_front();
            req_tvalid <= 1'b1;
            req_tdata  <= {cur_beat.shear, cur_beat.bulk, cur_beat.density, cur_beat.radius};
            req_tuser  <= cur_beat.kind;
         end
      end

      rsp_tready <= !reset && ($urandom_range(99) >= recv_idle_pct);
   end

   // ------------------------------------------------------------------
   // Stimulus generation
   // ------------------------------------------------------------------

   function automatic logic [39:0] rand_prop();
      logic [63:0] w;
      w = {$urandom, $urandom};
      case ($urandom_range(7))
         0:       return VAL_MAX;
         1:       return VAL_MIN;
         2:       return 40'(int'($urandom_range(2000)) - 1000);
         default: return w[39:0];
      endcase
   endfunction

   task automatic queue_beat(logic [1:0] kind, logic [31:0] radius,
                             logic [39:0] d, logic [39:0] b, logic [39:0] s);
      req_beat_type beat;
      beat.kind    = kind;
      beat.radius  = radius;
      beat.density = d;
      beat.bulk    = b;
      beat.shear   = s;
      beat.drain   = hold_next;
      hold_next    = 1'b0;
      pending_beats.insert(pending_beats.size(), beat);
      if (kind != REQ_UNUSED)
         item_total++;
      if (kind == REQ_CLEAR)
         table_plan.delete();
      if (kind == REQ_APPEND && table_plan.size() < TABLE_DEPTH)
         table_plan.insert(table_plan.size(), radius);
   endtask

   task automatic queue_random(logic [1:0] kind, logic [31:0] radius);
      queue_beat(kind, radius, rand_prop(), rand_prop(), rand_prop());
   endtask

   // Aim at knots, segment interiors, both ends and anywhere
   function automatic logic [31:0] pick_query_radius();
      int          n;
      int          j;
      logic [31:0] first;
      logic [31:0] last;
      n = table_plan.size();
      if (n == 0)
         return $urandom;
      j     = $urandom_range(n - 1);
      first = table_plan[0];
      last  = table_plan[n - 1];
      case ($urandom_range(9))
         0, 1: return table_plan[j];
         2, 3, 4, 5: begin
            if (j + 1 < n)
               return $urandom_range(table_plan[j], table_plan[j + 1]);
            return table_plan[j];
         end
         6: return (first == 0) ? 32'd0 : 32'($urandom_range(first - 1, 0));
         7: return (last == 32'hFFFF_FFFF) ? last : 32'($urandom_range(32'hFFFF_FFFF, last + 1));
         default: return $urandom;
      endcase
   endfunction

   task automatic build_directed();
      // empty table, unused code
      queue_random(REQ_QUERY, 32'd0);
      queue_beat(REQ_UNUSED, 32'hFFFF_FFFF, 40'hFF_FFFF_FFFF, 40'hFF_FFFF_FFFF, 40'hFF_FFFF_FFFF);
      // extremes, a zero-width segment and a full-span segment
      queue_beat(REQ_APPEND, 32'd0, VAL_MAX, VAL_MIN, 40'd0);
      queue_beat(REQ_APPEND, 32'd0, VAL_MIN, VAL_MAX, 40'hFF_FFFF_FFFF);
      queue_beat(REQ_APPEND, 32'hFFFF_FFFF, VAL_MAX, VAL_MIN, 40'd1);
      queue_random(REQ_QUERY, 32'd0);
      queue_random(REQ_QUERY, 32'hFFFF_FFFF);
      queue_random(REQ_QUERY, 32'h8000_0000);
      queue_random(REQ_QUERY, 32'h7FFF_FFFF);
      // single knot: below, on and above it
      queue_random(REQ_CLEAR, 32'd0);
      queue_random(REQ_APPEND, 32'd1000);
      queue_random(REQ_QUERY, 32'd999);
      queue_random(REQ_QUERY, 32'd1000);
      queue_random(REQ_QUERY, 32'hFFFF_FFFF);
      // descending knot: segment never matches
      queue_random(REQ_APPEND, 32'd500);
      queue_random(REQ_QUERY, 32'd700);
      queue_random(REQ_QUERY, 32'd1200);
      queue_random(REQ_QUERY, 32'd0);
      queue_beat(REQ_UNUSED, 32'd0, 40'd0, 40'd0, 40'd0);
      queue_random(REQ_CLEAR, 32'hFFFF_FFFF);
      queue_random(REQ_QUERY, 32'd5);
   endtask

   task automatic build_random();
      int          seq;
      int          roll;
      int          knots;
      int          style;
      int          queries;
      int          k;
      logic [31:0] rad;
      logic [31:0] span;
      seq = 0;
      while (item_total < ITEM_GOAL) begin
         hold_next = (seq == 0) || ($urandom_range(11) == 0);
         if (seq == 0 || $urandom_range(7) != 0)
            queue_random(REQ_CLEAR, $urandom);

         // table size: mostly small, now and then full and beyond
         roll = $urandom_range(99);
         if (seq == 2 || roll < 2)
            knots = $urandom_range(TABLE_DEPTH + 6, TABLE_DEPTH);
         else if (roll < 6)
            knots = 0;
         else if (roll < 26)
            knots = $urandom_range(40, 9);
         else
            knots = $urandom_range(8, 1);

         // radius layout: wide ascending, tight ascending or shuffled
         style = $urandom_range(9);
         if (style <= 5) begin
            rad  = $urandom >> $urandom_range(8, 1);
            span = (32'hFFFF_FFFF - rad) / ((knots == 0) ? 1 : knots);
         end else begin
            rad  = $urandom_range(32'hFFFF_F000, 0);
            span = 32'd7;
         end
         for (k = 0; k < knots; k++) begin
            if ($urandom_range(19) == 0)
               queue_random(REQ_UNUSED, $urandom);
            queue_random(REQ_APPEND, (style == 9) ? 32'($urandom) : rad);
            rad = rad + $urandom_range(span, 0);
         end

         queries = (knots > 200) ? 3 : $urandom_range(8, 1);
         for (k = 0; k < queries; k++)
            queue_random(REQ_QUERY, pick_query_radius());
         seq++;
      end
   endtask

   // ------------------------------------------------------------------
   // Run control
   // ------------------------------------------------------------------

   initial begin
      build_directed();
      build_random();
      total_beats = pending_beats.size();

      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      while (pending_beats.size() != 0 || req_tvalid)
         @(posedge clock);
      while (expected_results.size() != 0)
         @(posedge clock);
      repeat (600) @(posedge clock);

      if (error_count == 0)
         $display("SUCCESS");
      else
         $display("FAILURE");
      $finish;
   end

   // Watchdog
   initial begin
      #60_000_000;
      $display("FAILURE");
      $finish;
   end

endmodule

FILE: sim.f
design/plti_pkg.sv
design/plti_ram.sv
design/plti_muldiv.sv
design/piecewise_linear_table_interp.sv
design/plti_checker.sv
verif/tb.sv
